FILE: sv/lmpim_pkg.sv
// ----------------------------------------------------------------------------
// lmpim_pkg
// Shared widths, register indexes, layout flag bits and config structs.
// ----------------------------------------------------------------------------
package lmpim_pkg;

	localparam int MAX_TILE_DIM       = 64;
	localparam int MAX_TILES_PER_AXIS = 16;

	localparam int DIM_W     = 7;   // tile_width, tile_height
	localparam int CNT_W     = 5;   // tiles_across, tiles_down
	localparam int FLAG_W    = 8;
	localparam int ROT_W     = 2;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 3;
	localparam int COORD_W   = 12;
	localparam int POS_W     = 11;  // display sizes up to 1024, positions up to 1023
	localparam int QUO_W     = 4;   // tile column or row inside the grid
	localparam int SUB_W     = 6;   // pixel position inside one tile
	localparam int TILE_W    = 8;   // tile number along the chain
	localparam int PIX_W     = 12;  // pixel number inside one tile
	localparam int AREA_W    = 13;
	localparam int IDX_W     = 20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TILE_WIDTH   = 3'd0,
		REG_TILE_HEIGHT  = 3'd1,
		REG_TILES_ACROSS = 3'd2,
		REG_TILES_DOWN   = 3'd3,
		REG_LAYOUT_FLAGS = 3'd4,
		REG_ROTATION     = 3'd5
	} reg_idx_t;

	// quarter turns
	localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
	localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
	localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
	localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

	localparam int FLAG_PIX_RIGHT   = 0;
	localparam int FLAG_PIX_BOTTOM  = 1;
	localparam int FLAG_PIX_COLS    = 2;
	localparam int FLAG_PIX_ZIGZAG  = 3;
	localparam int FLAG_TILE_RIGHT  = 4;
	localparam int FLAG_TILE_BOTTOM = 5;
	localparam int FLAG_TILE_COLS   = 6;
	localparam int FLAG_TILE_ZIGZAG = 7;

	typedef struct packed {
		logic [DIM_W-1:0]  tile_width;
		logic [DIM_W-1:0]  tile_height;
		logic [CNT_W-1:0]  tiles_across;
		logic [CNT_W-1:0]  tiles_down;
		logic [FLAG_W-1:0] flags;
		logic [ROT_W-1:0]  rotation;
	} cfg_t;

	typedef struct packed {
		logic               tiled;
		logic [POS_W-1:0]   width;
		logic [POS_W-1:0]   height;
		logic [POS_W-1:0]   log_width;
		logic [POS_W-1:0]   log_height;
		logic [AREA_W-1:0]  area;
	} geom_t;

endpackage

FILE: sv/led_matrix_pixel_index_map_core.sv
// ----------------------------------------------------------------------------
// led_matrix_pixel_index_map_core
// Throughput: one coordinate per cycle unless out_stall holds the pipeline;
// five register stages (range and rotation, two divider stages,
// tile/pixel placement, offset multiply).
// Reset empties the pipeline and loads 16x8 untiled, no rotation, no flags.
// ----------------------------------------------------------------------------
module led_matrix_pixel_index_map_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lmpim_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [lmpim_pkg::CFG_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [lmpim_pkg::COORD_W-1:0] coord_x,
	input  logic signed [lmpim_pkg::COORD_W-1:0] coord_y,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [lmpim_pkg::IDX_W-1:0]         led_index,
	output logic                                in_range
);
	import lmpim_pkg::*;

	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_TILE_DIM * MAX_TILES_PER_AXIS - 1);

	cfg_t  cfg;
	geom_t geom;

	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic in_range_s1, in_range_s2, in_range_s3, in_range_s4, in_range_s5;

	logic [POS_W-1:0] x_u;
	logic [POS_W-1:0] y_u;
	logic             on_display;
	logic [POS_W-1:0] px;
	logic [POS_W-1:0] py;
	logic [POS_W-1:0] px_s1;
	logic [POS_W-1:0] py_s1;

	logic [POS_W-1:0] rem_x_s2, rem_y_s2, rem_x_s3, rem_y_s3;
	logic [QUO_W-1:0] quo_x_s2, quo_y_s2, quo_x_s3, quo_y_s3;

	logic [TILE_W-1:0]        tile_pos_s4;
	logic [PIX_W-1:0]         pix_pos_s4;
	logic [TILE_W+AREA_W-1:0] tile_off;
	logic [IDX_W-1:0]         index_sum;
	logic [IDX_W-1:0]         led_index_s5;

	lmpim_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg),
		.geom     (geom)
	);

	// a stage takes new data when empty or when its contents move on
	assign rdy5     = !valid_s5 || !out_stall;
	assign rdy4     = !valid_s4 || rdy5;
	assign rdy3     = !valid_s3 || rdy4;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
		end
	end

	// stage 1: range check against the rotated size, then undo the rotation
	assign x_u = coord_x[POS_W-1:0];
	assign y_u = coord_y[POS_W-1:0];
	assign on_display = !coord_x[COORD_W-1] && !coord_y[COORD_W-1] &&
	                    (x_u < geom.log_width) && (y_u < geom.log_height);

	always_comb begin
		case (cfg.rotation)
			ROT_90: begin
				px = geom.width - POS_W'(1) - y_u;
				py = x_u;
			end
			ROT_180: begin
				px = geom.width - POS_W'(1) - x_u;
				py = geom.height - POS_W'(1) - y_u;
			end
			ROT_270: begin
				px = y_u;
				py = geom.height - POS_W'(1) - x_u;
			end
			default: begin
				px = x_u;
				py = y_u;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			in_range_s1 <= on_display;
			px_s1       <= px;
			py_s1       <= py;
		end
		if (rdy2) in_range_s2 <= in_range_s1;
		if (rdy3) in_range_s3 <= in_range_s2;
		if (rdy4) in_range_s4 <= in_range_s3;
	end

	// stages 2 and 3: split position into tile and position inside the tile
	lmpim_div2 u_div_x_hi (
		.clk     (clk),
		.en      (rdy2),
		.rem_in  (px_s1),
		.quo_in  ('0),
		.dsh     (POS_W'(cfg.tile_width) << 2),
		.rem_out (rem_x_s2),
		.quo_out (quo_x_s2)
	);

	lmpim_div2 u_div_y_hi (
		.clk     (clk),
		.en      (rdy2),
		.rem_in  (py_s1),
		.quo_in  ('0),
		.dsh     (POS_W'(cfg.tile_height) << 2),
		.rem_out (rem_y_s2),
		.quo_out (quo_y_s2)
	);

	lmpim_div2 u_div_x_lo (
		.clk     (clk),
		.en      (rdy3),
		.rem_in  (rem_x_s2),
		.quo_in  (quo_x_s2),
		.dsh     (POS_W'(cfg.tile_width)),
		.rem_out (rem_x_s3),
		.quo_out (quo_x_s3)
	);

	lmpim_div2 u_div_y_lo (
		.clk     (clk),
		.en      (rdy3),
		.rem_in  (rem_y_s2),
		.quo_in  (quo_y_s2),
		.dsh     (POS_W'(cfg.tile_height)),
		.rem_out (rem_y_s3),
		.quo_out (quo_y_s3)
	);

	// stage 4: chain order of tiles and of pixels inside a tile
	lmpim_locate u_locate (
		.clk      (clk),
		.en       (rdy4),
		.cfg      (cfg),
		.tiled    (geom.tiled),
		.col      (quo_x_s3),
		.row      (quo_y_s3),
		.sub_x    (rem_x_s3[SUB_W-1:0]),
		.sub_y    (rem_y_s3[SUB_W-1:0]),
		.tile_pos (tile_pos_s4),
		.pix_pos  (pix_pos_s4)
	);

	// stage 5: tile offset and final index
	assign tile_off  = tile_pos_s4 * geom.area;
	assign index_sum = (geom.tiled ? tile_off[IDX_W-1:0] : IDX_W'(0)) +
	                   IDX_W'(pix_pos_s4);

	always_ff @(posedge clk) begin
		if (rdy5) begin
			in_range_s5  <= in_range_s4;
			led_index_s5 <= in_range_s4 ? index_sum : '0;
		end
	end

	assign out_valid = valid_s5;
	assign in_range  = in_range_s5;
	assign led_index = led_index_s5;

	// input side only stalls when every stage holds a transaction
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5))
		else $error("input stalled with a free pipeline stage");

	// unrotated positions never leave the largest display
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && in_range_s1) |-> (px_s1 <= POS_MAX && py_s1 <= POS_MAX))
		else $error("unrotated position beyond display bound");

	// off-display results carry a zero index
	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !in_range) |-> (led_index == '0))
		else $error("off-display transaction with nonzero index");

endmodule

FILE: sv/lmpim_cfg.sv
// ----------------------------------------------------------------------------
// lmpim_cfg
// Configuration registers with saturation, and the display geometry
// derived from them.
// ----------------------------------------------------------------------------
module lmpim_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lmpim_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [lmpim_pkg::CFG_W-1:0]    cfg_data,
	output lmpim_pkg::cfg_t                cfg,
	output lmpim_pkg::geom_t               geom
);
	import lmpim_pkg::*;

	localparam logic [DIM_W-1:0] TILE_WIDTH_RST  = DIM_W'(16);
	localparam logic [DIM_W-1:0] TILE_HEIGHT_RST = DIM_W'(8);

	logic [DIM_W-1:0]  tile_width_q;
	logic [DIM_W-1:0]  tile_height_q;
	logic [CNT_W-1:0]  tiles_across_q;
	logic [CNT_W-1:0]  tiles_down_q;
	logic [FLAG_W-1:0] flags_q;
	logic [ROT_W-1:0]  rotation_q;

	logic [CNT_W-1:0]       n_tiles;
	logic [CNT_W-1:0]       m_tiles;
	logic [DIM_W+CNT_W-1:0] width_full;
	logic [DIM_W+CNT_W-1:0] height_full;
	logic [2*DIM_W-1:0]     area_full;
	logic                   tiled;

	function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
		return (v > DIM_W'(MAX_TILE_DIM)) ? DIM_W'(MAX_TILE_DIM) : v;
	endfunction

	function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] v);
		return (v > CNT_W'(MAX_TILES_PER_AXIS)) ? CNT_W'(MAX_TILES_PER_AXIS) : v;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_width_q   <= TILE_WIDTH_RST;
			tile_height_q  <= TILE_HEIGHT_RST;
			tiles_across_q <= '0;
			tiles_down_q   <= '0;
			flags_q        <= '0;
			rotation_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_TILE_WIDTH:   tile_width_q   <= sat_dim(cfg_data[DIM_W-1:0]);
				REG_TILE_HEIGHT:  tile_height_q  <= sat_dim(cfg_data[DIM_W-1:0]);
				REG_TILES_ACROSS: tiles_across_q <= sat_cnt(cfg_data[CNT_W-1:0]);
				REG_TILES_DOWN:   tiles_down_q   <= sat_cnt(cfg_data[CNT_W-1:0]);
				REG_LAYOUT_FLAGS: flags_q        <= cfg_data[FLAG_W-1:0];
				REG_ROTATION:     rotation_q     <= cfg_data[ROT_W-1:0];
				default: ;
			endcase
		end
	end

	// untiled display counts as one tile each way
	assign tiled       = (tiles_across_q != '0);
	assign n_tiles     = tiled ? tiles_across_q : CNT_W'(1);
	assign m_tiles     = tiled ? tiles_down_q : CNT_W'(1);
	assign width_full  = tile_width_q * n_tiles;
	assign height_full = tile_height_q * m_tiles;
	assign area_full   = tile_width_q * tile_height_q;

	always_comb begin
		cfg.tile_width   = tile_width_q;
		cfg.tile_height  = tile_height_q;
		cfg.tiles_across = tiles_across_q;
		cfg.tiles_down   = tiles_down_q;
		cfg.flags        = flags_q;
		cfg.rotation     = rotation_q;

		geom.tiled  = tiled;
		geom.width  = width_full[POS_W-1:0];
		geom.height = height_full[POS_W-1:0];
		geom.area   = area_full[AREA_W-1:0];
		// quarter turns swap the logical axes
		if (rotation_q[0]) begin
			geom.log_width  = height_full[POS_W-1:0];
			geom.log_height = width_full[POS_W-1:0];
		end else begin
			geom.log_width  = width_full[POS_W-1:0];
			geom.log_height = height_full[POS_W-1:0];
		end
	end

endmodule

FILE: sv/lmpim_div2.sv
// ----------------------------------------------------------------------------
// lmpim_div2
// One registered stage of a restoring divider: two quotient bits per stage.
// ----------------------------------------------------------------------------
module lmpim_div2 (
	input  logic                        clk,
	input  logic                        en,
	input  logic [lmpim_pkg::POS_W-1:0] rem_in,
	input  logic [lmpim_pkg::QUO_W-1:0] quo_in,
	input  logic [lmpim_pkg::POS_W-1:0] dsh,
	output logic [lmpim_pkg::POS_W-1:0] rem_out,
	output logic [lmpim_pkg::QUO_W-1:0] quo_out
);
	import lmpim_pkg::*;

	logic [POS_W-1:0] d_hi;
	logic [POS_W-1:0] r_mid;
	logic [POS_W-1:0] r_lo;
	logic             b_hi;
	logic             b_lo;
	logic [POS_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;

	// dsh is the divisor shifted to the lower of the two bit weights
	assign d_hi = dsh << 1;

	always_comb begin
		b_hi  = (rem_in >= d_hi);
		r_mid = b_hi ? (rem_in - d_hi) : rem_in;
		b_lo  = (r_mid >= dsh);
		r_lo  = b_lo ? (r_mid - dsh) : r_mid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= r_lo;
			quo_q <= {quo_in[QUO_W-3:0], b_hi, b_lo};
		end
	end

	assign rem_out = rem_q;
	assign quo_out = quo_q;

endmodule

FILE: sv/lmpim_locate.sv
// ----------------------------------------------------------------------------
// lmpim_locate
// Registered stage that turns tile column/row and the pixel inside the tile
// into the tile number and the pixel number along the chain.
// ----------------------------------------------------------------------------
module lmpim_locate (
	input  logic                         clk,
	input  logic                         en,
	input  lmpim_pkg::cfg_t              cfg,
	input  logic                         tiled,
	input  logic [lmpim_pkg::QUO_W-1:0]  col,
	input  logic [lmpim_pkg::QUO_W-1:0]  row,
	input  logic [lmpim_pkg::SUB_W-1:0]  sub_x,
	input  logic [lmpim_pkg::SUB_W-1:0]  sub_y,
	output logic [lmpim_pkg::TILE_W-1:0] tile_pos,
	output logic [lmpim_pkg::PIX_W-1:0]  pix_pos
);
	import lmpim_pkg::*;

	logic [CNT_W-1:0]   tcol;
	logic [CNT_W-1:0]   trow;
	logic [CNT_W-1:0]   tminor;
	logic [CNT_W-1:0]   tmajor;
	logic [CNT_W-1:0]   tscale;
	logic [CNT_W-1:0]   tline;
	logic [2*CNT_W-1:0] tsum;
	logic               t_flip;
	logic [1:0]         corner;
	logic [DIM_W-1:0]   pcol;
	logic [DIM_W-1:0]   prow;
	logic [DIM_W-1:0]   pminor;
	logic [DIM_W-1:0]   pmajor;
	logic [DIM_W-1:0]   pscale;
	logic [DIM_W-1:0]   pline;
	logic [2*DIM_W-1:0] psum;
	logic [TILE_W-1:0]  tile_pos_q;
	logic [PIX_W-1:0]   pix_pos_q;

	always_comb begin
		// tile grid
		tcol = CNT_W'(col);
		trow = CNT_W'(row);
		if (cfg.flags[FLAG_TILE_RIGHT]) begin
			tcol = cfg.tiles_across - CNT_W'(1) - tcol;
		end
		if (cfg.flags[FLAG_TILE_BOTTOM]) begin
			trow = cfg.tiles_down - CNT_W'(1) - trow;
		end
		if (cfg.flags[FLAG_TILE_COLS]) begin
			tminor = trow;
			tmajor = tcol;
			tscale = cfg.tiles_down;
		end else begin
			tminor = tcol;
			tmajor = trow;
			tscale = cfg.tiles_across;
		end
		t_flip = cfg.flags[FLAG_TILE_ZIGZAG] && tmajor[0];
		tline  = t_flip ? (tscale - CNT_W'(1) - tminor) : tminor;
		tsum   = tmajor * tscale + (2*CNT_W)'(tline);

		// odd lines of a zigzag tiling enter the tile from the opposite corner
		corner = cfg.flags[FLAG_PIX_BOTTOM:FLAG_PIX_RIGHT] ^ {2{tiled && t_flip}};

		// pixels inside the tile
		pcol = DIM_W'(sub_x);
		prow = DIM_W'(sub_y);
		if (corner[0]) begin
			pcol = cfg.tile_width - DIM_W'(1) - pcol;
		end
		if (corner[1]) begin
			prow = cfg.tile_height - DIM_W'(1) - prow;
		end
		if (cfg.flags[FLAG_PIX_COLS]) begin
			pminor = prow;
			pmajor = pcol;
			pscale = cfg.tile_height;
		end else begin
			pminor = pcol;
			pmajor = prow;
			pscale = cfg.tile_width;
		end
		if (cfg.flags[FLAG_PIX_ZIGZAG] && pmajor[0]) begin
			pline = pscale - DIM_W'(1) - pminor;
		end else begin
			pline = pminor;
		end
		psum = pmajor * pscale + (2*DIM_W)'(pline);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tile_pos_q <= tsum[TILE_W-1:0];
			pix_pos_q  <= psum[PIX_W-1:0];
		end
	end

	assign tile_pos = tile_pos_q;
	assign pix_pos  = pix_pos_q;

endmodule

FILE: sim/tb_led_matrix_pixel_index_map_core.sv
// ----------------------------------------------------------------------------
// tb_led_matrix_pixel_index_map_core
// Drives coordinates through the pixel index map under a series of tile,
// layout and rotation settings and checks every led_index and in_range
// against a software model of the mapping. Both handshakes are throttled.
// ----------------------------------------------------------------------------
module tb_led_matrix_pixel_index_map_core;

	timeunit 1ns;
	timeprecision 1ps;

	import lmpim_pkg::*;

	// write indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} coord_t;

	typedef struct packed {
		logic [IDX_W-1:0] led_index;
		logic             in_range;
	} pixel_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx  = '0;
	logic [CFG_W-1:0]    cfg_data  = '0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	logic [COORD_W-1:0]  coord_x   = '0;
	logic [COORD_W-1:0]  coord_y   = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [IDX_W-1:0]    led_index;
	logic                in_range;

	coord_t coord_q[$];
	pixel_t led_q[$];
	cfg_t   shadow;
	int     errors        = 0;
	int     send_gap_pct  = 0;
	int     recv_stall_pct = 0;
	bit     hold          = 1'b0;

	led_matrix_pixel_index_map_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.led_index (led_index),
		.in_range  (in_range)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// mapping model
	// ------------------------------------------------------------------------
	function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		case (idx)
			REG_TILE_WIDTH:   shadow.tile_width   =
				(data[DIM_W-1:0] > DIM_W'(MAX_TILE_DIM)) ? DIM_W'(MAX_TILE_DIM) : data[DIM_W-1:0];
			REG_TILE_HEIGHT:  shadow.tile_height  =
				(data[DIM_W-1:0] > DIM_W'(MAX_TILE_DIM)) ? DIM_W'(MAX_TILE_DIM) : data[DIM_W-1:0];
			REG_TILES_ACROSS: shadow.tiles_across =
				(data[CNT_W-1:0] > CNT_W'(MAX_TILES_PER_AXIS)) ?
					CNT_W'(MAX_TILES_PER_AXIS) : data[CNT_W-1:0];
			REG_TILES_DOWN:   shadow.tiles_down   =
				(data[CNT_W-1:0] > CNT_W'(MAX_TILES_PER_AXIS)) ?
					CNT_W'(MAX_TILES_PER_AXIS) : data[CNT_W-1:0];
			REG_LAYOUT_FLAGS: shadow.flags        = data;
			REG_ROTATION:     shadow.rotation     = data[ROT_W-1:0];
			default: ;
		endcase
	endfunction

	// unrotated display size in pixels
	function automatic void display_size(output int unsigned w, output int unsigned h);
		bit tiled;
		tiled = shadow.tiles_across != 0;
		w = shadow.tile_width * (tiled ? int'(shadow.tiles_across) : 1);
		h = shadow.tile_height * (tiled ? int'(shadow.tiles_down) : 1);
	endfunction

	function automatic int unsigned chain_pos(input int unsigned mn, input int unsigned mj,
			input int unsigned line_len, input bit zigzag);
		if (zigzag && mj[0])
			return (mj + 1) * line_len - 1 - mn;
		return mj * line_len + mn;
	endfunction

	function automatic pixel_t map_pixel(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy);
		int          sx, sy;
		int unsigned w, h, lw, lh, x, y, px, py, tw, th, na, nd;
		int unsigned mn, mj, t, line_len, tile_off, pix;
		logic [1:0]  corner;
		pixel_t      r;
		r = '0;
		sx = int'($signed(cx));
		sy = int'($signed(cy));
		tw = 32'(shadow.tile_width);
		th = 32'(shadow.tile_height);
		na = 32'(shadow.tiles_across);
		nd = 32'(shadow.tiles_down);
		display_size(w, h);
		lw = shadow.rotation[0] ? h : w;
		lh = shadow.rotation[0] ? w : h;
		if (sx < 0 || sy < 0 || sx >= int'(lw) || sy >= int'(lh))
			return r;
		x = sx;
		y = sy;
		case (shadow.rotation)
			ROT_90:  begin px = w - 1 - y; py = x; end
			ROT_180: begin px = w - 1 - x; py = h - 1 - y; end
			ROT_270: begin px = y; py = h - 1 - x; end
			default: begin px = x; py = y; end
		endcase
		corner = shadow.flags[1:0];
		tile_off = 0;
		if (na != 0) begin
			mn = px / tw;
			mj = py / th;
			px -= mn * tw;
			py -= mj * th;
			if (shadow.flags[FLAG_TILE_RIGHT])
				mn = na - 1 - mn;
			if (shadow.flags[FLAG_TILE_BOTTOM])
				mj = nd - 1 - mj;
			if (shadow.flags[FLAG_TILE_COLS]) begin
				t = mn; mn = mj; mj = t;
				line_len = nd;
			end else begin
				line_len = na;
			end
			// odd tile lines of a zigzag grid enter from the opposite corner
			if (shadow.flags[FLAG_TILE_ZIGZAG] && mj[0])
				corner ^= 2'b11;
			tile_off = chain_pos(mn, mj, line_len, shadow.flags[FLAG_TILE_ZIGZAG]) * tw * th;
		end
		mn = px;
		mj = py;
		if (corner[0])
			mn = tw - 1 - mn;
		if (corner[1])
			mj = th - 1 - mj;
		if (shadow.flags[FLAG_PIX_COLS]) begin
			t = mn; mn = mj; mj = t;
			line_len = th;
		end else begin
			line_len = tw;
		end
		pix = chain_pos(mn, mj, line_len, shadow.flags[FLAG_PIX_ZIGZAG]);
		r.led_index = IDX_W'(tile_off + pix);
		r.in_range  = 1'b1;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// coordinate driver
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			coord_x  <= '0;
			coord_y  <= '0;
		end else begin : drive
			int left;
			left = coord_q.size();
			if (in_valid && !in_stall) begin
				led_q.push_back(map_pixel(coord_q[0].x, coord_q[0].y));
				void'(coord_q.pop_front());
				left--;
			end
			if (!in_valid || !in_stall) begin
				if (left > 0 && !hold && $urandom_range(99) >= send_gap_pct) begin
					in_valid <= 1'b1;
					coord_x  <= coord_q[0].x;
					coord_y  <= coord_q[0].y;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// result monitor
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin : watch
			pixel_t want;
			if (out_valid && !out_stall) begin
				if (led_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected transaction, led_index %0d in_range %0b",
						$time, led_index, in_range);
				end else begin
					want = led_q.pop_front();
					if (led_index !== want.led_index) begin
						errors++;
						$display("%0t: led_index expected %0d actual %0d",
							$time, want.led_index, led_index);
					end
					if (in_range !== want.in_range) begin
						errors++;
						$display("%0t: in_range expected %0b actual %0b",
							$time, want.in_range, in_range);
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		store_reg(idx, data);
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	task automatic write_all(input logic [CFG_W-1:0] tw, input logic [CFG_W-1:0] th,
			input logic [CFG_W-1:0] na, input logic [CFG_W-1:0] nd,
			input logic [CFG_W-1:0] flags, input logic [CFG_W-1:0] rot);
		write_reg(REG_TILE_WIDTH, tw);
		write_reg(REG_TILE_HEIGHT, th);
		write_reg(REG_TILES_ACROSS, na);
		write_reg(REG_TILES_DOWN, nd);
		write_reg(REG_LAYOUT_FLAGS, flags);
		write_reg(REG_ROTATION, rot);
	endtask

	task automatic add(input int x, input int y);
		coord_q.push_back('{x[COORD_W-1:0], y[COORD_W-1:0]});
	endtask

	// wait until every transaction has come back, then let the pipeline empty
	task automatic drain();
		@(negedge clk);
		while (coord_q.size() != 0 || in_valid || led_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// mostly from -1 up to the logical size, sometimes edge values or anywhere in the 12-bit range
	function automatic logic [COORD_W-1:0] pick_coord(input int unsigned span);
		case ($urandom_range(9))
			0: return COORD_W'($urandom);
			1: begin
				case ($urandom_range(3))
					0: return '1;
					1: return 12'h800;
					2: return 12'h7FF;
					default: return span[COORD_W-1:0];
				endcase
			end
			default: return COORD_W'($urandom_range(span + 1) - 1);
		endcase
	endfunction

	task automatic add_random(input int n);
		int unsigned w, h, lw, lh;
		display_size(w, h);
		lw = shadow.rotation[0] ? h : w;
		lh = shadow.rotation[0] ? w : h;
		repeat (n)
			coord_q.push_back('{pick_coord(lw), pick_coord(lh)});
	endtask

	// a quarter of the batch, a pause until the block has emptied, then the rest
	task automatic run_setting(input int n);
		@(negedge clk);
		add_random(n / 2);
		while (coord_q.size() > n / 4)
			@(negedge clk);
		hold = 1'b1;
		while (in_valid || led_q.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
		hold = 1'b0;
		add_random(n - n / 2);
		drain();
	endtask

	initial begin : stimulus
		int s;
		shadow = '{tile_width: 16, tile_height: 8, tiles_across: 0, tiles_down: 0,
			flags: 0, rotation: ROT_0};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset geometry: 16 by 8, untiled
		@(negedge clk);
		add(0, 0);
		add(15, 7);
		add(15, 0);
		add(0, 7);
		add(16, 0);
		add(0, 8);
		add(-1, 0);
		add(0, -1);
		add(-2048, -2048);
		add(2047, 2047);
		add(2047, -2048);
		add(-2048, 2047);
		drain();

		// oversized writes clamp to the largest grid
		write_all(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, CFG_W'(ROT_270));
		@(negedge clk);
		add(0, 0);
		add(1023, 1023);
		add(1024, 0);
		add(500, 3);
		drain();

		// writes beyond the last register change nothing
		write_reg(REG_SPARE_A, 8'h01);
		write_reg(REG_SPARE_B, 8'h01);
		@(negedge clk);
		add(1023, 0);
		drain();

		// empty display: no tile rows
		write_reg(REG_TILES_DOWN, 8'h00);
		@(negedge clk);
		add(0, 0);
		drain();

		// empty display: zero tile width, untiled
		write_all(8'h80, 8'h04, 8'h00, 8'h04, 8'h00, CFG_W'(ROT_0));
		@(negedge clk);
		add(0, 0);
		drain();

		write_all(8'h01, 8'h01, 8'h00, 8'h00, 8'h00, CFG_W'(ROT_180));
		@(negedge clk);
		add(0, 0);
		add(1, 0);
		add(0, 1);
		drain();

		for (s = 0; s < 12; s++) begin
			case (s / 4)
				0: begin send_gap_pct = 6;  recv_stall_pct = 50; end
				1: begin send_gap_pct = 50; recv_stall_pct = 6;  end
				default: begin send_gap_pct = 0; recv_stall_pct = 0; end
			endcase
			if (s == 0)
				write_all(8'd64, 8'd64, 8'd16, 8'd16,
					CFG_W'($urandom_range(255)), CFG_W'($urandom_range(3)));
			else if (s == 4)
				write_all(8'd1, 8'd1, 8'd16, 8'd16,
					CFG_W'($urandom_range(255)), CFG_W'($urandom_range(3)));
			else if (s == 8)
				write_all(8'd1, 8'd64, 8'd0, 8'd0,
					CFG_W'($urandom_range(255)), CFG_W'($urandom_range(3)));
			else
				write_all(
					CFG_W'(($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(1, 16)),
					CFG_W'(($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(1, 16)),
					CFG_W'(($urandom_range(4) == 0) ? 0 :
						(($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(1, 8))),
					CFG_W'(($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(1, 8)),
					CFG_W'($urandom_range(255)),
					CFG_W'($urandom_range(3)));
			run_setting(150);
		end

		drain();
		repeat (20) @(posedge clk);
		if (led_q.size() != 0)
			$display("%0t: %0d transactions never came back", $time, led_q.size());
		if (errors == 0 && led_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: led_matrix_pixel_index_map_core.f
sv/lmpim_pkg.sv
sv/lmpim_cfg.sv
sv/lmpim_div2.sv
sv/lmpim_locate.sv
sv/led_matrix_pixel_index_map_core.sv
sim/tb_led_matrix_pixel_index_map_core.sv
